>>> rtl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types, command and register codes for the fixed-point convolution
// layer.
// ----------------------------------------------------------------------------
package fpc_pkg;

   localparam int DATA_W         = 16;
   localparam int ACC_W          = 32;
   localparam int COEF_DEPTH     = 49;
   localparam int KERNEL_CAP     = 7;
   localparam int OUT_FIFO_DEPTH = 16;
   localparam int OUT_FIFO_AW    = $clog2(OUT_FIFO_DEPTH);
   localparam int OUT_FIFO_CW    = $clog2(OUT_FIFO_DEPTH + 1);

   localparam logic [1:0] CMD_COEF  = 2'd0;
   localparam logic [1:0] CMD_BIAS  = 2'd1;
   localparam logic [1:0] CMD_PIXEL = 2'd2;

   localparam logic [2:0] REG_KERNEL = 3'd0;
   localparam logic [2:0] REG_STRIDE = 3'd1;
   localparam logic [2:0] REG_FRAC   = 3'd2;
   localparam logic [2:0] REG_WIDTH  = 3'd3;
   localparam logic [2:0] REG_HEIGHT = 3'd4;
   localparam logic [2:0] REG_MAPS   = 3'd5;

   // output position that travels alongside a pixel through the pipeline
   typedef struct packed {
      logic                     pos;
      logic                     emit;
      logic                     first_map;
      logic                     last;
      logic [7:0]               row;
      logic [7:0]               col;
      logic [15:0]              addr;
      logic signed [DATA_W-1:0] bias;
   } pos_info_type;

   typedef struct packed {
      logic                     en;
      logic [5:0]               idx;
      logic signed [DATA_W-1:0] data;
   } coef_wr_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pixel;
      logic [7:0]               row;
      logic [7:0]               col;
      logic                     last;
   } out_beat_type;

   // coefficient for window lane (j rows back, i columns back) at kernel size k
   function automatic logic [5:0] coef_slot(input logic [2:0] k, input int j, input int i);
      int kr;
      int kc;
      kr = int'(k) - 1 - j;
      kc = int'(k) - 1 - i;
      if (kr < 0 || kc < 0) begin
         return 6'd0;
      end
      return 6'(kr * int'(k) + kc);
   endfunction

endpackage

>>> rtl/fpc_ram.sv
// ----------------------------------------------------------------------------
// fpc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fpc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fpc_linebuf.sv
// ----------------------------------------------------------------------------
// fpc_linebuf
// Line store (one word per column, one slot per row bank) and the sliding
// window fed from it, one column per pixel.
// ----------------------------------------------------------------------------
module fpc_linebuf #(
   parameter int MAX_KERNEL = 7,
   parameter int WIN        = 7,
   parameter int LINE_DEPTH = 256,
   parameter int BW         = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              px_valid,
   input  logic [7:0]                        px_col,
   input  logic [BW-1:0]                     px_bank,
   input  logic signed [fpc_pkg::DATA_W-1:0] px_value,
   output logic [WIN-1:0][WIN-1:0][fpc_pkg::DATA_W-1:0] win
);
   import fpc_pkg::*;

   localparam int AW = $clog2(LINE_DEPTH);

   logic [MAX_KERNEL-1:0][DATA_W-1:0] ram_q;
   logic [MAX_KERNEL-1:0][DATA_W-1:0] base;
   logic [MAX_KERNEL-1:0][DATA_W-1:0] merged;
   logic [MAX_KERNEL-1:0][DATA_W-1:0] fwd_word_ff;
   logic [WIN-1:0][DATA_W-1:0]        colv;
   logic [WIN-1:0][WIN-1:0][DATA_W-1:0] win_ff;
   logic [BW-1:0]                     sel;

   logic              v1_ff, v1_in;
   logic              fwd_ff, fwd_in;
   logic [AW-1:0]     col1_ff;
   logic [BW-1:0]     bank1_ff;
   logic [DATA_W-1:0] val1_ff;

   fpc_ram #(
      .WIDTH (MAX_KERNEL * DATA_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (v1_ff),
      .wr_addr (col1_ff),
      .wr_data (merged),
      .rd_en   (px_valid),
      .rd_addr (px_col[AW-1:0]),
      .rd_data (ram_q)
   );

   // column written back in the same cycle that this read was issued
   assign fwd_in = v1_ff && px_valid && (col1_ff == px_col[AW-1:0]);
   assign v1_in  = px_valid;

   always_comb begin
      base = fwd_ff ? fwd_word_ff : ram_q;
      for (int b = 0; b < MAX_KERNEL; b++) begin
         merged[b] = (bank1_ff == BW'(b)) ? val1_ff : base[b];
      end
   end

   // row j back from the newest row lives in bank (bank - j) mod MAX_KERNEL
   always_comb begin
      sel = '0;
      for (int j = 0; j < WIN; j++) begin
         sel = (bank1_ff >= BW'(j)) ? (bank1_ff - BW'(j)) : (bank1_ff + BW'(MAX_KERNEL - j));
         colv[j] = merged[sel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         v1_ff  <= v1_in;
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      col1_ff     <= px_col[AW-1:0];
      bank1_ff    <= px_bank;
      val1_ff     <= px_value;
      fwd_word_ff <= merged;
      if (v1_ff) begin
         for (int j = 0; j < WIN; j++) begin
            win_ff[j][0] <= colv[j];
            for (int i = 1; i < WIN; i++) begin
               win_ff[j][i] <= win_ff[j][i-1];
            end
         end
      end
   end

   assign win = win_ff;

endmodule

>>> rtl/fpc_mac.sv
// ----------------------------------------------------------------------------
// fpc_mac
// Coefficient registers, one multiplier per window lane, registered adder
// tree and the fixed-point scaling of the window sum.
// ----------------------------------------------------------------------------
module fpc_mac #(
   parameter int WIN = 7
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  fpc_pkg::coef_wr_type                        coef_wr,
   input  logic [2:0]                                  kernel,
   input  logic [4:0]                                  frac,
   input  logic [WIN-1:0][WIN-1:0][fpc_pkg::DATA_W-1:0] win,
   input  fpc_pkg::pos_info_type                       info_in,
   output logic signed [fpc_pkg::DATA_W-1:0]           term,
   output fpc_pkg::pos_info_type                       info_out
);
   import fpc_pkg::*;

   logic signed [DATA_W-1:0] coef_ff [COEF_DEPTH];
   logic [WIN-1:0][WIN-1:0][ACC_W-1:0] prod_in, prod_ff;
   logic [WIN-1:0][ACC_W-1:0]          row_in, row_ff;
   logic [ACC_W-1:0]                   sop_in, sop_ff;
   logic signed [ACC_W-1:0]            shifted;
   logic signed [DATA_W-1:0]           term_in, term_ff;
   pos_info_type                       info3_ff, info4_ff, info5_ff, info6_ff;

   always_comb begin
      for (int j = 0; j < WIN; j++) begin
         for (int i = 0; i < WIN; i++) begin
            if (j < int'(kernel) && i < int'(kernel)) begin
               prod_in[j][i] = $signed(win[j][i]) * coef_ff[coef_slot(kernel, j, i)];
            end else begin
               prod_in[j][i] = '0;
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < WIN; j++) begin
         row_in[j] = '0;
         for (int i = 0; i < WIN; i++) begin
            row_in[j] = row_in[j] + prod_ff[j][i];
         end
      end
      sop_in = '0;
      for (int j = 0; j < WIN; j++) begin
         sop_in = sop_in + row_ff[j];
      end
   end

   assign shifted = $signed(sop_ff) >>> frac;
   assign term_in = shifted[DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < COEF_DEPTH; n++) begin
            coef_ff[n] <= '0;
         end
         info3_ff <= '0;
         info4_ff <= '0;
         info5_ff <= '0;
         info6_ff <= '0;
      end else begin
         if (coef_wr.en && (coef_wr.idx < 6'(COEF_DEPTH))) begin
            coef_ff[coef_wr.idx] <= coef_wr.data;
         end
         info3_ff <= info_in;
         info4_ff <= info3_ff;
         info5_ff <= info4_ff;
         info6_ff <= info5_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      row_ff  <= row_in;
      sop_ff  <= sop_in;
      term_ff <= term_in;
   end

   assign term     = term_ff;
   assign info_out = info6_ff;

endmodule

>>> rtl/fpc_accum.sv
// ----------------------------------------------------------------------------
// fpc_accum
// Per-position accumulator memory (read, add, write back), bias add and the
// result queue toward the output channel.
// ----------------------------------------------------------------------------
module fpc_accum #(
   parameter int MAX_OUT_PIXELS = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [fpc_pkg::DATA_W-1:0] term_in,
   input  fpc_pkg::pos_info_type             info_in,
   input  logic                              pop,
   output logic                              rsp_valid,
   output fpc_pkg::out_beat_type             rsp_beat
);
   import fpc_pkg::*;

   localparam int AW = $clog2(MAX_OUT_PIXELS);

   logic                     in_range, rd_en, we, fwd_in, push;
   logic [ACC_W-1:0]         ram_q, prior, acc;
   logic [DATA_W-1:0]        res;
   pos_info_type             info7_ff;
   logic signed [DATA_W-1:0] term7_ff;
   logic                     range7_ff;
   logic                     fwd_ff;
   logic [ACC_W-1:0]         fwd_data_ff;
   out_beat_type             fifo_ff [OUT_FIFO_DEPTH];
   out_beat_type             beat_in;
   logic [OUT_FIFO_AW-1:0]   wptr_ff, rptr_ff;
   logic [OUT_FIFO_CW-1:0]   count_ff, count_in;

   assign in_range = {1'b0, info_in.addr} < 17'(MAX_OUT_PIXELS);
   assign rd_en    = info_in.pos && in_range;

   fpc_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MAX_OUT_PIXELS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (info7_ff.addr[AW-1:0]),
      .wr_data (acc),
      .rd_en   (rd_en),
      .rd_addr (info_in.addr[AW-1:0]),
      .rd_data (ram_q)
   );

   // first map starts from zero, positions past the store read as zero
   always_comb begin
      if (!info7_ff.first_map && range7_ff) begin
         prior = fwd_ff ? fwd_data_ff : ram_q;
      end else begin
         prior = '0;
      end
      acc = ACC_W'(term7_ff) + prior;
      res = acc[DATA_W-1:0] + info7_ff.bias;
   end

   assign we     = info7_ff.pos && range7_ff;
   assign fwd_in = we && rd_en && (info7_ff.addr[AW-1:0] == info_in.addr[AW-1:0]);
   assign push   = info7_ff.pos && info7_ff.emit;

   always_comb begin
      beat_in.pixel = res;
      beat_in.row   = info7_ff.row;
      beat_in.col   = info7_ff.col;
      beat_in.last  = info7_ff.last;
      count_in      = count_ff + OUT_FIFO_CW'(push) - OUT_FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         info7_ff <= '0;
         fwd_ff   <= 1'b0;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         info7_ff <= info_in;
         fwd_ff   <= fwd_in;
         count_ff <= count_in;
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      term7_ff    <= term_in;
      range7_ff   <= in_range;
      fwd_data_ff <= acc;
      if (push) begin
         fifo_ff[wptr_ff] <= beat_in;
      end
   end

   assign rsp_valid = count_ff != '0;
   assign rsp_beat  = fifo_ff[rptr_ff];

endmodule

>>> rtl/fixed_point_conv_layer.sv
// ----------------------------------------------------------------------------
// fixed_point_conv_layer
// One output map of a strided fixed-point convolution summed over input maps.
// ----------------------------------------------------------------------------
// Takes one beat per clock while req_ready is high: coefficient and bias
// writes, then the pixels of each padded input map in raster order. A result
// moves from the pixel that completes its window via line store read, window
// shift, multiply, two adder stages, scaling, then the accumulator
// read-modify-write. Up to 16 results may wait on the output; req_ready drops
// only while that many are reserved. Both memories start undefined and need
// no clearing pass, since every entry is written in a stream before it is
// read. Writing any register restarts the stream; coefficients and bias are kept.
module fixed_point_conv_layer #(
   parameter int MAX_KERNEL     = 7,
   parameter int MAX_LINE_WIDTH = 256,
   parameter int MAX_OUT_PIXELS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [5:0]  req_coeff_index,
   input  logic signed [fpc_pkg::DATA_W-1:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [fpc_pkg::DATA_W-1:0] rsp_out_pixel,
   output logic [7:0]  rsp_out_row,
   output logic [7:0]  rsp_out_col,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import fpc_pkg::*;

   localparam int WIN        = (MAX_KERNEL < KERNEL_CAP) ? MAX_KERNEL : KERNEL_CAP;
   localparam int LINE_DEPTH = (MAX_LINE_WIDTH < 256) ? MAX_LINE_WIDTH : 256;
   localparam int BW         = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam logic [2:0] K_RESET = 3'((WIN < 3) ? WIN : 3);

   logic [2:0] k_ff, k_in, s_ff, s_in;
   logic [4:0] frac_ff, frac_in;
   logic [8:0] w_ff, w_in, h_ff, h_in, m_ff, m_in;
   logic [7:0] r_ff, r_in, c_ff, c_in, map_ff, map_in;
   logic [7:0] orow_ff, orow_in, ocol_ff, ocol_in;
   logic [15:0] oaddr_ff, oaddr_in;
   logic [2:0] rph_ff, rph_in, cph_ff, cph_in;
   logic [BW-1:0] bank_ff, bank_in;
   logic signed [DATA_W-1:0] bias_ff, bias_in;
   logic [OUT_FIFO_CW-1:0] cnt_ff, cnt_in;

   logic accept, acc_pix, cfg_hit, pop;
   logic [8:0] r1, c1, k9, s9;
   logic rv, cv, pos, map_last, col_end, row_end, last;
   logic [3:0] rph_next, cph_next;

   pos_info_type info0, info1_ff, info2_ff, mac_info;
   coef_wr_type  cw0, cw1_ff;
   logic [WIN-1:0][WIN-1:0][DATA_W-1:0] win;
   logic signed [DATA_W-1:0] term;
   out_beat_type beat;

   assign csr_ready = 1'b1;
   assign cfg_hit   = csr_valid && csr_ready && (csr_index <= REG_MAPS);
   assign req_ready = cnt_ff < OUT_FIFO_CW'(OUT_FIFO_DEPTH);
   assign accept    = req_valid && req_ready;
   assign acc_pix   = accept && (req_command == CMD_PIXEL);
   assign pop       = rsp_valid && rsp_ready;

   // position of the incoming pixel
   always_comb begin
      r1       = {1'b0, r_ff} + 9'd1;
      c1       = {1'b0, c_ff} + 9'd1;
      k9       = {6'd0, k_ff};
      s9       = {6'd0, s_ff};
      rv       = (r1 >= k9) && (rph_ff == 3'd0);
      cv       = (c1 >= k9) && (cph_ff == 3'd0);
      pos      = (req_command == CMD_PIXEL) && rv && cv;
      map_last = ({1'b0, map_ff} + 9'd1) >= m_ff;
      col_end  = c1 >= w_ff;
      row_end  = r1 >= h_ff;
      last     = (({1'b0, r_ff} + s9) >= h_ff) && (({1'b0, c_ff} + s9) >= w_ff);
      rph_next = {1'b0, rph_ff} + 4'd1;
      cph_next = {1'b0, cph_ff} + 4'd1;
   end

   always_comb begin
      info0.pos       = pos;
      info0.emit      = pos && map_last;
      info0.first_map = map_ff == 8'd0;
      info0.last      = last;
      info0.row       = orow_ff;
      info0.col       = ocol_ff;
      info0.addr      = oaddr_ff;
      info0.bias      = bias_ff;
      cw0.en          = accept && (req_command == CMD_COEF);
      cw0.idx         = req_coeff_index;
      cw0.data        = req_value;
   end

   // registers, clamped on write
   always_comb begin
      k_in    = k_ff;
      s_in    = s_ff;
      frac_in = frac_ff;
      w_in    = w_ff;
      h_in    = h_ff;
      m_in    = m_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_KERNEL: begin
               k_in = (csr_data[2:0] == 3'd0) ? 3'd1 :
                      (int'(csr_data[2:0]) > WIN) ? 3'(WIN) : csr_data[2:0];
            end
            REG_STRIDE: begin
               s_in = (csr_data[2:0] == 3'd0) ? 3'd1 : csr_data[2:0];
            end
            REG_FRAC: begin
               frac_in = csr_data[4:0];
            end
            REG_WIDTH: begin
               w_in = (csr_data == 9'd0) ? 9'd1 :
                      (int'(csr_data) > LINE_DEPTH) ? 9'(LINE_DEPTH) : csr_data;
            end
            REG_HEIGHT: begin
               h_in = (csr_data == 9'd0) ? 9'd1 : (csr_data > 9'd256) ? 9'd256 : csr_data;
            end
            REG_MAPS: begin
               m_in = (csr_data == 9'd0) ? 9'd1 : (csr_data > 9'd256) ? 9'd256 : csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // raster counters and the stride phase of the window corner
   always_comb begin
      r_in     = r_ff;
      c_in     = c_ff;
      map_in   = map_ff;
      orow_in  = orow_ff;
      ocol_in  = ocol_ff;
      oaddr_in = oaddr_ff;
      rph_in   = rph_ff;
      cph_in   = cph_ff;
      bank_in  = bank_ff;
      if (cfg_hit) begin
         r_in     = '0;
         c_in     = '0;
         map_in   = '0;
         orow_in  = '0;
         ocol_in  = '0;
         oaddr_in = '0;
         rph_in   = '0;
         cph_in   = '0;
         bank_in  = '0;
      end else if (acc_pix) begin
         oaddr_in = oaddr_ff + 16'(pos);
         if (col_end) begin
            c_in    = '0;
            cph_in  = '0;
            ocol_in = '0;
            if (row_end) begin
               r_in     = '0;
               rph_in   = '0;
               bank_in  = '0;
               orow_in  = '0;
               oaddr_in = '0;
               map_in   = map_last ? 8'd0 : map_ff + 8'd1;
            end else begin
               r_in    = r_ff + 8'd1;
               bank_in = (bank_ff == BW'(MAX_KERNEL - 1)) ? '0 : bank_ff + 1'b1;
               rph_in  = (r1 < k9) ? 3'd0 : (rph_next >= {1'b0, s_ff}) ? 3'd0 : rph_next[2:0];
               orow_in = rv ? orow_ff + 8'd1 : orow_ff;
            end
         end else begin
            c_in    = c_ff + 8'd1;
            cph_in  = (c1 < k9) ? 3'd0 : (cph_next >= {1'b0, s_ff}) ? 3'd0 : cph_next[2:0];
            ocol_in = cv ? ocol_ff + 8'd1 : ocol_ff;
         end
      end
   end

   assign bias_in = (accept && (req_command == CMD_BIAS)) ? req_value : bias_ff;
   assign cnt_in  = cnt_ff + OUT_FIFO_CW'(accept && info0.emit) - OUT_FIFO_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= K_RESET;
         s_ff     <= 3'd1;
         frac_ff  <= 5'd15;
         w_ff     <= 9'(32 < LINE_DEPTH ? 32 : LINE_DEPTH);
         h_ff     <= 9'd32;
         m_ff     <= 9'd1;
         r_ff     <= '0;
         c_ff     <= '0;
         map_ff   <= '0;
         orow_ff  <= '0;
         ocol_ff  <= '0;
         oaddr_ff <= '0;
         rph_ff   <= '0;
         cph_ff   <= '0;
         bank_ff  <= '0;
         bias_ff  <= '0;
         cnt_ff   <= '0;
         info1_ff <= '0;
         info2_ff <= '0;
         cw1_ff   <= '0;
      end else begin
         k_ff     <= k_in;
         s_ff     <= s_in;
         frac_ff  <= frac_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         m_ff     <= m_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         map_ff   <= map_in;
         orow_ff  <= orow_in;
         ocol_ff  <= ocol_in;
         oaddr_ff <= oaddr_in;
         rph_ff   <= rph_in;
         cph_ff   <= cph_in;
         bank_ff  <= bank_in;
         bias_ff  <= bias_in;
         cnt_ff   <= cnt_in;
         info1_ff <= accept ? info0 : '0;
         info2_ff <= info1_ff;
         // coefficient write is registered here, in step with the window
         cw1_ff   <= cw0;
      end
   end

   fpc_linebuf #(
      .MAX_KERNEL (MAX_KERNEL),
      .WIN        (WIN),
      .LINE_DEPTH (LINE_DEPTH),
      .BW         (BW)
   ) u_linebuf (
      .clock    (clock),
      .reset    (reset),
      .px_valid (acc_pix),
      .px_col   (c_ff),
      .px_bank  (bank_ff),
      .px_value (req_value),
      .win      (win)
   );

   fpc_mac #(
      .WIN (WIN)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .coef_wr  (cw1_ff),
      .kernel   (k_ff),
      .frac     (frac_ff),
      .win      (win),
      .info_in  (info2_ff),
      .term     (term),
      .info_out (mac_info)
   );

   fpc_accum #(
      .MAX_OUT_PIXELS (MAX_OUT_PIXELS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .term_in   (term),
      .info_in   (mac_info),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_beat  (beat)
   );

   assign rsp_out_pixel = beat.pixel;
   assign rsp_out_row   = beat.row;
   assign rsp_out_col   = beat.col;
   assign rsp_last      = beat.last;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= OUT_FIFO_CW'(OUT_FIFO_DEPTH))
      else $error("result credit count overran the output queue");

   a_rsp_reserved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cnt_ff != '0))
      else $error("result beat offered without a reserved credit");

   a_col_in_map: assert property (@(posedge clock) disable iff (reset)
      {1'b0, c_ff} < w_ff)
      else $error("column counter outside the map width");

   a_bank_range: assert property (@(posedge clock) disable iff (reset)
      int'(bank_ff) < MAX_KERNEL)
      else $error("line store bank index out of range");

endmodule
